>>> rtl/core/dbws_pkg.sv
// ----------------------------------------------------------------------------
// dbws_pkg
// Shared types and constants of the daily backlight window scheduler.
// ----------------------------------------------------------------------------
package dbws_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_SYNC_TZ = 2'd1;
    localparam logic [1:0] OP_SYNC    = 2'd2;
    localparam logic [1:0] OP_APPLY   = 2'd3;

    localparam logic [1:0] CFG_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_OFF_MINUTE = 2'd1;
    localparam logic [1:0] CFG_ON_MINUTE  = 2'd2;

    localparam logic signed [10:0] TZ_LOW  = -11'sd720;
    localparam logic signed [10:0] TZ_HIGH = 11'sd840;

    // Reciprocal of 1875 scaled by 2^55, split at bit 32.
    localparam logic [12:0] RECIP_HI = 13'd4473;
    localparam logic [31:0] RECIP_LO = 32'd3969695107;
    localparam int unsigned RECIP_SHIFT = 55;

    // Floor reciprocal of 45 scaled by 2^16.
    localparam logic [22:0] RECIP45 = 23'd1456;
    localparam logic [11:0] MOD45   = 12'd45;
    localparam logic [6:0]  MOD45_N = 7'd45;

    localparam logic signed [12:0] DAY_MINUTES = 13'sd1440;

    typedef struct packed {
        logic               check;
        logic               force_on;
        logic signed [10:0] tz;
    } dbws_ctrl_t;

endpackage

>>> rtl/core/dbws_front.sv
// ----------------------------------------------------------------------------
// dbws_front
// Input stage: keeps the clock anchor, time zone and check timer, decides
// whether the item runs a check and forms the current epoch time.
// ----------------------------------------------------------------------------
module dbws_front #(
    parameter int unsigned CHECK_PERIOD_MS = 1000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enabled,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [31:0]         now_ms,
    input  logic [47:0]         epoch_ms,
    input  logic signed [10:0]  tz_offset_min,
    output logic                a_valid,
    input  logic                a_stall,
    output logic [48:0]         a_cur,
    output dbws_pkg::dbws_ctrl_t a_ctrl
);

    logic [47:0]          base_epoch_reg;
    logic [47:0]          base_epoch_next;
    logic [31:0]          base_counter_reg;
    logic [31:0]          base_counter_next;
    logic                 clock_valid_reg;
    logic                 clock_valid_next;
    logic signed [10:0]   tz_reg;
    logic signed [10:0]   tz_next;
    logic [31:0]          next_check_reg;
    logic [31:0]          next_check_next;
    logic                 a_valid_reg;
    logic [48:0]          cur_reg;
    logic [48:0]          cur_next;
    dbws_pkg::dbws_ctrl_t ctrl_reg;
    dbws_pkg::dbws_ctrl_t ctrl_next;
    logic                 stage_free;
    logic                 accept;
    logic                 do_sync;
    logic                 tick_due;
    logic                 tick_run;
    logic                 is_apply;
    logic signed [10:0]   tz_clamped;
    logic [31:0]          elapsed;

    assign stage_free = !a_valid_reg || !a_stall;
    assign in_stall   = !stage_free;
    assign accept     = in_valid && stage_free;

    always_comb
    begin
        is_apply = (operation == dbws_pkg::OP_APPLY);
        do_sync  = (operation != dbws_pkg::OP_TICK) && (epoch_ms != 48'd0);
        elapsed  = now_ms - next_check_reg;
        tick_due = !elapsed[31];
        tick_run = (operation == dbws_pkg::OP_TICK) && tick_due;

        if (tz_offset_min < dbws_pkg::TZ_LOW)
        begin
            tz_clamped = dbws_pkg::TZ_LOW;
        end
        else if (tz_offset_min > dbws_pkg::TZ_HIGH)
        begin
            tz_clamped = dbws_pkg::TZ_HIGH;
        end
        else
        begin
            tz_clamped = tz_offset_min;
        end

        if ((operation == dbws_pkg::OP_SYNC_TZ) || is_apply)
        begin
            tz_next = tz_clamped;
        end
        else
        begin
            tz_next = tz_reg;
        end

        base_epoch_next   = do_sync ? epoch_ms : base_epoch_reg;
        base_counter_next = do_sync ? now_ms : base_counter_reg;
        clock_valid_next  = clock_valid_reg || do_sync;

        if (tick_run)
        begin
            next_check_next = now_ms + 32'(CHECK_PERIOD_MS);
        end
        else if (is_apply)
        begin
            next_check_next = 32'd0;
        end
        else
        begin
            next_check_next = next_check_reg;
        end

        if (do_sync)
        begin
            cur_next = {1'b0, epoch_ms};
        end
        else
        begin
            cur_next = {1'b0, base_epoch_reg} + {17'd0, now_ms - base_counter_reg};
        end

        ctrl_next.check    = (tick_run || is_apply) && enabled && clock_valid_next;
        ctrl_next.force_on = is_apply && !enabled;
        ctrl_next.tz       = tz_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_epoch_reg   <= '0;
            base_counter_reg <= '0;
            clock_valid_reg  <= 1'b0;
            tz_reg           <= '0;
            next_check_reg   <= '0;
            a_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                base_epoch_reg   <= base_epoch_next;
                base_counter_reg <= base_counter_next;
                clock_valid_reg  <= clock_valid_next;
                tz_reg           <= tz_next;
                next_check_reg   <= next_check_next;
            end
            if (stage_free)
            begin
                a_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg  <= cur_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_cur   = cur_reg;
    assign a_ctrl  = ctrl_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        clock_valid_reg |=> clock_valid_reg)
        else $error("clock anchor lost after a sync");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation == dbws_pkg::OP_APPLY) |=> next_check_reg == 32'd0)
        else $error("check timer not cleared by apply");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !clock_valid_reg && !do_sync |=> !ctrl_reg.check)
        else $error("check issued without a synced clock");

endmodule

>>> rtl/core/dbws_minute.sv
// ----------------------------------------------------------------------------
// dbws_minute
// Minute-of-day pipeline: divides the epoch time by 60000 with a split
// reciprocal product, then folds the minute count toward its remainder modulo 1440.
// ----------------------------------------------------------------------------
module dbws_minute (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 a_valid,
    output logic                 a_stall,
    input  logic [48:0]          a_cur,
    input  dbws_pkg::dbws_ctrl_t a_ctrl,
    output logic                 d_valid,
    input  logic                 d_stall,
    output logic [11:0]          d_fold,
    output logic [6:0]           d_quot,
    output logic [4:0]           d_low5,
    output dbws_pkg::dbws_ctrl_t d_ctrl
);

    logic                 p_valid_reg;
    logic                 u_valid_reg;
    logic                 d_valid_reg;
    logic                 p_free;
    logic                 u_free;
    logic                 d_free;

    logic [43:0]          scaled;
    logic [63:0]          pll_next;
    logic [44:0]          plh_next;
    logic [43:0]          phl_next;
    logic [24:0]          phh_next;
    logic [63:0]          pll_reg;
    logic [44:0]          plh_reg;
    logic [43:0]          phl_reg;
    logic [24:0]          phh_reg;
    dbws_pkg::dbws_ctrl_t p_ctrl_reg;

    logic [88:0]          total;
    logic [33:0]          u_next;
    logic [33:0]          u_reg;
    dbws_pkg::dbws_ctrl_t u_ctrl_reg;

    logic [13:0]          sum1;
    logic [12:0]          sum2;
    logic [11:0]          fold_next;
    logic [22:0]          quot_prod;
    logic [11:0]          fold_reg;
    logic [6:0]           quot_reg;
    logic [4:0]           low5_reg;
    dbws_pkg::dbws_ctrl_t d_ctrl_reg;

    assign d_free  = !d_valid_reg || !d_stall;
    assign u_free  = !u_valid_reg || d_free;
    assign p_free  = !p_valid_reg || u_free;
    assign a_stall = !p_free;

    always_comb
    begin
        scaled   = a_cur[48:5];
        pll_next = {32'd0, scaled[31:0]} * {32'd0, dbws_pkg::RECIP_LO};
        plh_next = {13'd0, scaled[31:0]} * {32'd0, dbws_pkg::RECIP_HI};
        phl_next = {32'd0, scaled[43:32]} * {12'd0, dbws_pkg::RECIP_LO};
        phh_next = {13'd0, scaled[43:32]} * {12'd0, dbws_pkg::RECIP_HI};
    end

    always_comb
    begin
        total = {25'd0, pll_reg}
              + (({44'd0, plh_reg} + {45'd0, phl_reg}) << 32)
              + ({64'd0, phh_reg} << 64);
        u_next = total[88:dbws_pkg::RECIP_SHIFT];
    end

    // Since 2^12 is 1 modulo 45, 12-bit digits may simply be added.
    always_comb
    begin
        sum1      = {2'd0, u_reg[16:5]} + {2'd0, u_reg[28:17]} + {9'd0, u_reg[33:29]};
        sum2      = {1'b0, sum1[11:0]} + {11'd0, sum1[13:12]};
        fold_next = sum2[11:0] + {11'd0, sum2[12]};
        quot_prod = {11'd0, fold_next} * dbws_pkg::RECIP45;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            u_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_free)
            begin
                p_valid_reg <= a_valid;
            end
            if (u_free)
            begin
                u_valid_reg <= p_valid_reg;
            end
            if (d_free)
            begin
                d_valid_reg <= u_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_free && a_valid)
        begin
            pll_reg    <= pll_next;
            plh_reg    <= plh_next;
            phl_reg    <= phl_next;
            phh_reg    <= phh_next;
            p_ctrl_reg <= a_ctrl;
        end
        if (u_free && p_valid_reg)
        begin
            u_reg      <= u_next;
            u_ctrl_reg <= p_ctrl_reg;
        end
        if (d_free && u_valid_reg)
        begin
            fold_reg   <= fold_next;
            quot_reg   <= quot_prod[22:16];
            low5_reg   <= u_reg[4:0];
            d_ctrl_reg <= u_ctrl_reg;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_fold  = fold_reg;
    assign d_quot  = quot_reg;
    assign d_low5  = low5_reg;
    assign d_ctrl  = d_ctrl_reg;

endmodule

>>> rtl/core/dbws_decide.sv
// ----------------------------------------------------------------------------
// dbws_decide
// Result stage: finishes the minute of day, applies the time zone, tests the
// off window, updates the backlight state and holds the result register.
// ----------------------------------------------------------------------------
module dbws_decide (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [10:0]          off_minute,
    input  logic [10:0]          on_minute,
    input  logic                 d_valid,
    output logic                 d_stall,
    input  logic [11:0]          d_fold,
    input  logic [6:0]           d_quot,
    input  logic [4:0]           d_low5,
    input  dbws_pkg::dbws_ctrl_t d_ctrl,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 backlight_on,
    output logic                 changed,
    output logic                 evaluated,
    output logic [10:0]          local_minute
);

    logic               out_valid_reg;
    logic               screen_on_reg;
    logic               screen_on_next;
    logic               changed_reg;
    logic               changed_next;
    logic               evaluated_reg;
    logic [10:0]        minute_reg;
    logic [10:0]        minute_next;
    logic               out_free;
    logic               load;
    logic [6:0]         rem_raw;
    logic [5:0]         rem;
    logic [10:0]        utc_minute;
    logic signed [12:0] local_sum;
    logic signed [12:0] local_wrap;
    logic [10:0]        local_min;
    logic               in_off;
    logic               want_on;
    logic               screen_mid;

    assign out_free = !out_valid_reg || !out_stall;
    assign d_stall  = !out_free;
    assign load     = d_valid && out_free;

    always_comb
    begin
        rem_raw    = 7'(d_fold - 12'(d_quot) * dbws_pkg::MOD45);
        rem        = (rem_raw >= dbws_pkg::MOD45_N) ? 6'(rem_raw - dbws_pkg::MOD45_N)
                                                    : rem_raw[5:0];
        utc_minute = {rem, d_low5};
        local_sum  = $signed({2'b00, utc_minute}) + $signed({{2{d_ctrl.tz[10]}}, d_ctrl.tz});

        if (local_sum < 13'sd0)
        begin
            local_wrap = local_sum + dbws_pkg::DAY_MINUTES;
        end
        else if (local_sum >= dbws_pkg::DAY_MINUTES)
        begin
            local_wrap = local_sum - dbws_pkg::DAY_MINUTES;
        end
        else
        begin
            local_wrap = local_sum;
        end
        local_min = local_wrap[10:0];

        if (off_minute == on_minute)
        begin
            in_off = 1'b0;
        end
        else if (off_minute < on_minute)
        begin
            in_off = (local_min >= off_minute) && (local_min < on_minute);
        end
        else
        begin
            in_off = (local_min >= off_minute) || (local_min < on_minute);
        end
        want_on = !in_off;

        screen_mid   = screen_on_reg || d_ctrl.force_on;
        changed_next = d_ctrl.force_on && !screen_on_reg;
        if (d_ctrl.check)
        begin
            screen_on_next = want_on;
            changed_next   = changed_next || (want_on != screen_mid);
            minute_next    = local_min;
        end
        else
        begin
            screen_on_next = screen_mid;
            minute_next    = 11'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            screen_on_reg <= 1'b1;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= d_valid;
            end
            if (load)
            begin
                screen_on_reg <= screen_on_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            changed_reg   <= changed_next;
            evaluated_reg <= d_ctrl.check;
            minute_reg    <= minute_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign backlight_on = screen_on_reg;
    assign changed      = changed_reg;
    assign evaluated    = evaluated_reg;
    assign local_minute = minute_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && changed && !evaluated |-> backlight_on)
        else $error("forced change left the backlight off");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evaluated |-> local_minute == 11'd0)
        else $error("minute reported without a check");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evaluated |-> local_minute < 11'd1440)
        else $error("local minute out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        load && !changed_next |=> backlight_on == $past(screen_on_reg))
        else $error("backlight moved without a change flag");

endmodule

>>> rtl/core/daily_backlight_window_scheduler.sv
// ----------------------------------------------------------------------------
// daily_backlight_window_scheduler
// An item passes the input, product, sum, fold and result registers in turn.
// Throughput: one item per cycle while out_stall is low; the five pipeline
// stages run concurrently. The division by 60000 is split over a product stage
// and a sum stage. Reset clears the clock anchor, time zone, check timer and
// configuration and leaves the backlight on.
// ----------------------------------------------------------------------------
module daily_backlight_window_scheduler #(
    parameter int unsigned CHECK_PERIOD_MS = 1000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [31:0]        now_ms,
    input  logic [47:0]        epoch_ms,
    input  logic signed [10:0] tz_offset_min,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               backlight_on,
    output logic               changed,
    output logic               evaluated,
    output logic [10:0]        local_minute
);

    logic                 enabled_reg;
    logic [10:0]          off_minute_reg;
    logic [10:0]          on_minute_reg;
    logic                 a_valid;
    logic                 a_stall;
    logic [48:0]          a_cur;
    dbws_pkg::dbws_ctrl_t a_ctrl;
    logic                 d_valid;
    logic                 d_stall;
    logic [11:0]          d_fold;
    logic [6:0]           d_quot;
    logic [4:0]           d_low5;
    dbws_pkg::dbws_ctrl_t d_ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            off_minute_reg <= '0;
            on_minute_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                dbws_pkg::CFG_ENABLED:    enabled_reg    <= cfg_data[0];
                dbws_pkg::CFG_OFF_MINUTE: off_minute_reg <= cfg_data;
                dbws_pkg::CFG_ON_MINUTE:  on_minute_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dbws_front #(
        .CHECK_PERIOD_MS(CHECK_PERIOD_MS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .enabled      (enabled_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .now_ms       (now_ms),
        .epoch_ms     (epoch_ms),
        .tz_offset_min(tz_offset_min),
        .a_valid      (a_valid),
        .a_stall      (a_stall),
        .a_cur        (a_cur),
        .a_ctrl       (a_ctrl)
    );

    dbws_minute u_minute (
        .clk    (clk),
        .rst_n  (rst_n),
        .a_valid(a_valid),
        .a_stall(a_stall),
        .a_cur  (a_cur),
        .a_ctrl (a_ctrl),
        .d_valid(d_valid),
        .d_stall(d_stall),
        .d_fold (d_fold),
        .d_quot (d_quot),
        .d_low5 (d_low5),
        .d_ctrl (d_ctrl)
    );

    dbws_decide u_decide (
        .clk         (clk),
        .rst_n       (rst_n),
        .off_minute  (off_minute_reg),
        .on_minute   (on_minute_reg),
        .d_valid     (d_valid),
        .d_stall     (d_stall),
        .d_fold      (d_fold),
        .d_quot      (d_quot),
        .d_low5      (d_low5),
        .d_ctrl      (d_ctrl),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .backlight_on(backlight_on),
        .changed     (changed),
        .evaluated   (evaluated),
        .local_minute(local_minute)
    );

endmodule

>>> verif/dbws_checker.sv
// ----------------------------------------------------------------------------
// dbws_checker
// Watches the configuration port and both transfer channels of the daily
// backlight window scheduler. It keeps its own copy of the wall clock anchor,
// time zone, check timer and backlight state. From these it works out the
// status that each accepted item must produce. Every result that leaves the
// block is compared field by field against the oldest pending status.
// ----------------------------------------------------------------------------
module dbws_checker #(
    parameter int unsigned CHECK_PERIOD_MS = 1000
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [31:0]        now_ms,
    input  logic [47:0]        epoch_ms,
    input  logic signed [10:0] tz_offset_min,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               backlight_on,
    input  logic               changed,
    input  logic               evaluated,
    input  logic [10:0]        local_minute,
    output int unsigned        failures,
    output int unsigned        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MS_PER_MINUTE   = 60000;
    localparam int              MINUTES_PER_DAY = 1440;

    typedef struct packed {
        logic        lamp;
        logic        toggled;
        logic        checked;
        logic [10:0] minute;
    } lamp_status_t;

    logic               sched_enabled;
    logic [10:0]        dark_from;
    logic [10:0]        dark_until;
    logic [63:0]        anchor_epoch;
    logic [31:0]        anchor_count;
    logic               anchor_valid;
    logic signed [10:0] zone_offset;
    logic               lamp_on;
    logic [31:0]        next_due;
    int unsigned        results_seen;

    lamp_status_t pending_status[$];

    function automatic logic signed [10:0] clamp_zone(input logic signed [10:0] raw);
        if (raw < dbws_pkg::TZ_LOW)
        begin
            return dbws_pkg::TZ_LOW;
        end
        if (raw > dbws_pkg::TZ_HIGH)
        begin
            return dbws_pkg::TZ_HIGH;
        end
        return raw;
    endfunction

    function automatic logic dark_at(input logic [10:0] minute);
        if (dark_from == dark_until)
        begin
            return 1'b0;
        end
        if (dark_from < dark_until)
        begin
            return (minute >= dark_from) && (minute < dark_until);
        end
        return (minute >= dark_from) || (minute < dark_until);
    endfunction

    task automatic anchor_clock(input logic [47:0] epoch, input logic [31:0] stamp);
        if (epoch != 48'd0)
        begin
            anchor_epoch = {16'd0, epoch};
            anchor_count = stamp;
            anchor_valid = 1'b1;
        end
    endtask

    task automatic check_window(input logic [31:0] stamp, inout lamp_status_t status);
        logic [31:0]     span;
        longint unsigned wall_ms;
        int              zone_int;
        int              day_minute;
        logic            want_on;
        if (sched_enabled && anchor_valid)
        begin
            span = stamp - anchor_count;
            wall_ms = anchor_epoch + {32'd0, span};
            zone_int = zone_offset;
            day_minute = int'((wall_ms / MS_PER_MINUTE) % longint'(MINUTES_PER_DAY));
            day_minute = (day_minute + MINUTES_PER_DAY + zone_int) % MINUTES_PER_DAY;
            status.checked = 1'b1;
            status.minute = 11'(day_minute);
            want_on = !dark_at(11'(day_minute));
            if (want_on != lamp_on)
            begin
                lamp_on = want_on;
                status.toggled = 1'b1;
            end
        end
    endtask

    task automatic predict_status(input logic [1:0] op, input logic [31:0] stamp,
                                  input logic [47:0] epoch, input logic signed [10:0] zone,
                                  output lamp_status_t status);
        logic [31:0] lag;
        status = '0;
        case (op)
            dbws_pkg::OP_TICK:
            begin
                lag = stamp - next_due;
                if (!lag[31])
                begin
                    next_due = stamp + CHECK_PERIOD_MS;
                    check_window(stamp, status);
                end
            end
            dbws_pkg::OP_SYNC_TZ:
            begin
                zone_offset = clamp_zone(zone);
                anchor_clock(epoch, stamp);
            end
            dbws_pkg::OP_SYNC:
            begin
                anchor_clock(epoch, stamp);
            end
            dbws_pkg::OP_APPLY:
            begin
                zone_offset = clamp_zone(zone);
                anchor_clock(epoch, stamp);
                if (!sched_enabled && !lamp_on)
                begin
                    lamp_on = 1'b1;
                    status.toggled = 1'b1;
                end
                next_due = 32'd0;
                check_window(stamp, status);
            end
            default: ;
        endcase
        status.lamp = lamp_on;
    endtask

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        lamp_status_t status;
        if (!rst_n)
        begin
            sched_enabled = 1'b0;
            dark_from = 11'd0;
            dark_until = 11'd0;
            anchor_epoch = 64'd0;
            anchor_count = 32'd0;
            anchor_valid = 1'b0;
            zone_offset = 11'sd0;
            lamp_on = 1'b1;
            next_due = 32'd0;
            results_seen = 0;
            pending_status.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    dbws_pkg::CFG_ENABLED:    sched_enabled = cfg_data[0];
                    dbws_pkg::CFG_OFF_MINUTE: dark_from = cfg_data;
                    dbws_pkg::CFG_ON_MINUTE:  dark_until = cfg_data;
                    default:                  ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_status.size() == 0)
                begin
                    log_failure($sformatf("result %0d arrived with no item pending",
                                          results_seen));
                end
                else
                begin
                    status = pending_status.pop_front();
                    if (backlight_on !== status.lamp || changed !== status.toggled ||
                        evaluated !== status.checked || local_minute !== status.minute)
                    begin
                        log_failure({
                            $sformatf("result %0d mismatch: expected on=%0b chg=%0b ",
                                      results_seen, status.lamp, status.toggled),
                            $sformatf("eval=%0b min=%0d, got on=%0b chg=%0b ",
                                      status.checked, status.minute, backlight_on,
                                      changed),
                            $sformatf("eval=%0b min=%0d", evaluated, local_minute)});
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_status(operation, now_ms, epoch_ms, tz_offset_min, status);
                pending_status.push_back(status);
            end
            outstanding = pending_status.size();
        end
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the daily backlight window scheduler with a short directed run of
// clock syncs, rate-limited ticks, offset clamping and forced-on cases, then
// with random sync and tick sequences aimed at the window boundaries under a
// range of schedule settings. The sender works in bursts, the receiver stalls
// on its own pattern and once holds off long enough to back up the block.
// Checking is done by dbws_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CHECK_PERIOD_MS = 1000;
    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int unsigned LONG_HOLD       = 300;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [1:0]         cfg_index;
    logic [10:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         operation;
    logic [31:0]        now_ms;
    logic [47:0]        epoch_ms;
    logic signed [10:0] tz_offset_min;
    logic               out_valid;
    logic               out_stall;
    logic               backlight_on;
    logic               changed;
    logic               evaluated;
    logic [10:0]        local_minute;
    int unsigned        failures;
    int unsigned        outstanding;

    int unsigned        hold_requests = 0;
    int unsigned        burst_left;
    logic [31:0]        stamp_ms;
    logic [10:0]        cur_off;
    logic [10:0]        cur_on;

    daily_backlight_window_scheduler #(
        .CHECK_PERIOD_MS(CHECK_PERIOD_MS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .now_ms       (now_ms),
        .epoch_ms     (epoch_ms),
        .tz_offset_min(tz_offset_min),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .backlight_on (backlight_on),
        .changed      (changed),
        .evaluated    (evaluated),
        .local_minute (local_minute)
    );

    dbws_checker #(
        .CHECK_PERIOD_MS(CHECK_PERIOD_MS)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .now_ms       (now_ms),
        .epoch_ms     (epoch_ms),
        .tz_offset_min(tz_offset_min),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .backlight_on (backlight_on),
        .changed      (changed),
        .evaluated    (evaluated),
        .local_minute (local_minute),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [47:0] day_epoch(input int unsigned day_index,
                                              input int unsigned minute,
                                              input int unsigned msec);
        longint unsigned total;
        total = 64'(day_index) * 64'd86400000 + 64'(minute) * 64'd60000 + 64'(msec);
        return total[47:0];
    endfunction

    function automatic logic [47:0] noise_epoch();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic signed [10:0] random_zone();
        if ($urandom_range(3) == 0)
        begin
            return 11'($urandom);
        end
        return 11'(int'($urandom_range(1560)) - 720);
    endfunction

    // Picks a UTC minute near a window boundary once the zone is applied, or any minute.
    function automatic int unsigned near_boundary_minute(input int zone);
        int target;
        case ($urandom_range(2))
            0:       target = int'(cur_off) + int'($urandom_range(3)) - 2;
            1:       target = int'(cur_on) + int'($urandom_range(3)) - 2;
            default: target = int'($urandom_range(1439));
        endcase
        return (target - zone + 4 * 1440) % 1440;
    endfunction

    task automatic transfer_item(input logic [1:0] op, input logic [31:0] stamp,
                                 input logic [47:0] epoch, input logic signed [10:0] zone);
        logic        taken;
        int unsigned gap;
        in_valid <= 1'b1;
        operation <= op;
        now_ms <= stamp;
        epoch_ms <= epoch;
        tz_offset_min <= zone;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(120, 40)
                                                  : $urandom_range(16, 1);
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(7, 1);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_schedule(input logic [10:0] enable_word, input logic [10:0] dark_from,
                                  input logic [10:0] dark_until);
        cfg_write_en <= 1'b1;
        cfg_index <= dbws_pkg::CFG_ENABLED;
        cfg_data <= enable_word;
        @(posedge clk);
        cfg_index <= dbws_pkg::CFG_OFF_MINUTE;
        cfg_data <= dark_from;
        @(posedge clk);
        cfg_index <= dbws_pkg::CFG_ON_MINUTE;
        cfg_data <= dark_until;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_off = dark_from;
        cur_on = dark_until;
    endtask

    task automatic run_random_traffic(input int unsigned count);
        int unsigned        done;
        int                 zone;
        logic signed [10:0] tz;
        logic [1:0]         op;
        logic [47:0]        epoch;
        done = 0;
        zone = 0;
        while (done < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                transfer_item(2'($urandom), $urandom, noise_epoch(), 11'($urandom));
                done++;
            end
            else
            begin
                tz = random_zone();
                if ($urandom_range(3) == 0)
                begin
                    stamp_ms = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(30000))
                                                        : $urandom;
                    op = dbws_pkg::OP_APPLY;
                end
                else
                begin
                    case ($urandom_range(2))
                        0:       op = dbws_pkg::OP_SYNC_TZ;
                        1:       op = dbws_pkg::OP_APPLY;
                        default: op = dbws_pkg::OP_SYNC;
                    endcase
                end
                if (op != dbws_pkg::OP_SYNC)
                begin
                    zone = tz;
                end
                epoch = day_epoch($urandom_range(25000), near_boundary_minute(zone),
                                  $urandom_range(59999));
                transfer_item(op, stamp_ms, epoch, tz);
                done++;
                repeat ($urandom_range(40, 4))
                begin
                    case ($urandom_range(11))
                        6:
                        begin
                            stamp_ms = stamp_ms + 32'($urandom_range(999));
                            transfer_item(dbws_pkg::OP_TICK, stamp_ms, noise_epoch(),
                                          11'($urandom));
                        end
                        7:
                        begin
                            stamp_ms = stamp_ms + 32'($urandom_range(120, 1) * 60000)
                                       + 32'($urandom_range(999));
                            transfer_item(dbws_pkg::OP_TICK, stamp_ms, noise_epoch(),
                                          11'($urandom));
                        end
                        8:
                        begin
                            stamp_ms = stamp_ms + 32'($urandom_range(200));
                            epoch = ($urandom_range(1) == 0) ? 48'd0 :
                                    day_epoch($urandom_range(25000), near_boundary_minute(zone),
                                              $urandom_range(59999));
                            transfer_item(dbws_pkg::OP_SYNC, stamp_ms, epoch, 11'($urandom));
                        end
                        9, 10:
                        begin
                            tz = random_zone();
                            zone = tz;
                            epoch = ($urandom_range(1) == 0) ? 48'd0 :
                                    day_epoch($urandom_range(25000), near_boundary_minute(zone),
                                              $urandom_range(59999));
                            transfer_item(($urandom_range(1) == 0) ? dbws_pkg::OP_APPLY
                                                                   : dbws_pkg::OP_SYNC_TZ,
                                          stamp_ms, epoch, tz);
                        end
                        11:
                        begin
                            stamp_ms = stamp_ms + 32'h7FFF_F000 + 32'($urandom_range(8192));
                            transfer_item(dbws_pkg::OP_TICK, stamp_ms, noise_epoch(),
                                          11'($urandom));
                            transfer_item(dbws_pkg::OP_APPLY, stamp_ms, 48'd0, 11'(zone));
                            done++;
                        end
                        default:
                        begin
                            stamp_ms = stamp_ms + 32'($urandom_range(1300, 900));
                            transfer_item(dbws_pkg::OP_TICK, stamp_ms, noise_epoch(),
                                          11'($urandom));
                        end
                    endcase
                    done++;
                end
            end
        end
    endtask

    initial
    begin : receiver
        int unsigned cyc;
        int unsigned hold_left;
        int unsigned served;
        out_stall = 1'b0;
        cyc = 0;
        hold_left = 0;
        served = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_left == 0 && served != hold_requests)
            begin
                served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                case ((cyc / 97) % 4)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(3) == 0);
                    2:       out_stall <= ($urandom_range(3) != 0);
                    default: out_stall <= ((cyc % 7) < 3);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = dbws_pkg::CFG_ENABLED;
        cfg_data = 11'd0;
        in_valid = 1'b0;
        operation = dbws_pkg::OP_TICK;
        now_ms = 32'd0;
        epoch_ms = 48'd0;
        tz_offset_min = 11'sd0;
        burst_left = 0;
        stamp_ms = 32'd0;
        cur_off = 11'd0;
        cur_on = 11'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_schedule(11'd1, 11'd1320, 11'd420);
        transfer_item(dbws_pkg::OP_TICK, 32'd5, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_SYNC, 32'd10, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_SYNC_TZ, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 11'h400);
        transfer_item(dbws_pkg::OP_TICK, 32'hFFFF_FFFF, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_TICK, 32'd1005, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_TICK, 32'd2004, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_SYNC_TZ, 32'd3000, 48'd1, 11'h3FF);
        transfer_item(dbws_pkg::OP_APPLY, 32'd4000, day_epoch(19000, 1320, 0), 11'sd0);
        transfer_item(dbws_pkg::OP_TICK, 32'd63999, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_APPLY, 32'd5000, day_epoch(19000, 419, 59999), 11'sd0);
        transfer_item(dbws_pkg::OP_TICK, 32'd5001, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_SYNC_TZ, 32'd6000, day_epoch(19000, 0, 0),
                      dbws_pkg::TZ_LOW);
        transfer_item(dbws_pkg::OP_TICK, 32'd6000, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_SYNC_TZ, 32'd7000, day_epoch(19000, 1000, 0),
                      dbws_pkg::TZ_HIGH);
        transfer_item(dbws_pkg::OP_TICK, 32'd7000, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_SYNC, 32'd8000, day_epoch(19000, 500, 0), 11'sd0);
        transfer_item(dbws_pkg::OP_TICK, 32'd8000, 48'd0, 11'sd0);
        drain_pipeline();
        write_schedule(11'h7FE, 11'd1320, 11'd420);
        transfer_item(dbws_pkg::OP_APPLY, 32'd9000, 48'd0, 11'sd0);
        transfer_item(dbws_pkg::OP_TICK, 32'd9001, 48'd0, 11'sd0);
        stamp_ms = 32'd9001;
        drain_pipeline();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       write_schedule({10'($urandom), 1'b1}, 11'd1320, 11'd420);
                1:       write_schedule({10'($urandom), 1'b1}, 11'd60, 11'd600);
                2:       write_schedule({10'($urandom), 1'b1}, 11'd700, 11'd700);
                3:       write_schedule({10'($urandom), 1'b1}, 11'd0, 11'd1439);
                4:       write_schedule({10'($urandom), 1'b1}, 11'd1439, 11'd0);
                5:       write_schedule({10'($urandom), 1'b0}, 11'd300, 11'd900);
                6:       write_schedule(11'h7FF, 11'd2047, 11'd1440);
                default: write_schedule(11'($urandom), 11'($urandom_range(1439)),
                                        11'($urandom_range(1439)));
            endcase
            if (phase == 1)
            begin
                hold_requests++;
            end
            run_random_traffic(240);
            drain_pipeline();
        end

        if (failures == 0 && outstanding == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
